// ----- design/rbsi_pkg.sv -----
// Shared constants and types for the ray/box slab intersection unit.
package rbsi_pkg;

  localparam int FRAC_BITS = 16;             // Q format fraction bits
  localparam int QBITS     = 31;             // quotient bits kept below saturation
  localparam int DIV_LAT   = QBITS + 2;      // divider register count
  localparam int R0_W      = FRAC_BITS + 1;  // width of the first partial remainder

  // Clamped slab time: -1 stands for any negative time, 2^QBITS for any
  // time past the largest distance limit.
  typedef logic signed [QBITS+1:0] slab_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  par;
    logic [2:0]  in_slab;
    logic [30:0] max_t;
  } side_t;

  typedef struct packed {
    logic              hit;
    logic [30:0]       hit_t;
    logic signed [1:0] nx;
    logic signed [1:0] ny;
    logic signed [1:0] nz;
  } result_t;

endpackage

// ----- design/rbsi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating.
module rbsi_div (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          nm,
  input  logic [31:0]          dm,
  input  logic                 neg,
  output rbsi_pkg::slab_t      t
);
  import rbsi_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  logic [31:0]       rem  [0:QBITS];
  logic [QBITS-1:0]  quo  [0:QBITS];
  logic [QBITS-1:0]  nlow [0:QBITS];
  logic [31:0]       dms  [0:QBITS];
  logic              negs [0:QBITS];
  logic              ovfs [0:QBITS];

  logic [NW-1:0]   numer;
  logic [R0_W-1:0] r0;
  logic [31:0]     mag;

  assign numer = {nm, {FRAC_BITS{1'b0}}};
  assign r0    = numer[NW-1:QBITS];

  // quotient reaches 2^QBITS exactly when the top part already covers dm
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= 32'(r0);
      quo[0]  <= '0;
      nlow[0] <= numer[QBITS-1:0];
      dms[0]  <= dm;
      negs[0] <= neg;
      ovfs[0] <= (32'(r0) >= dm);
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[k-1], nlow[k-1][QBITS-1]};
    assign ge    = (trial >= {1'b0, dms[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? 32'(trial - {1'b0, dms[k-1]}) : trial[31:0];
        quo[k]  <= {quo[k-1][QBITS-2:0], ge};
        nlow[k] <= {nlow[k-1][QBITS-2:0], 1'b0};
        dms[k]  <= dms[k-1];
        negs[k] <= negs[k-1];
        ovfs[k] <= ovfs[k-1];
      end
    end
  end

  assign mag = ovfs[QBITS] ? (32'd1 << QBITS) : {1'b0, quo[QBITS]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (negs[QBITS])
        t <= (mag != 32'd0) ? '1 : '0;
      else
        t <= $signed({1'b0, mag});
    end
  end

endmodule

// ----- design/rbsi_fold.sv -----
// Slab ordering and per-axis interval narrowing, one axis per stage.
module rbsi_fold (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  rbsi_pkg::slab_t [2:0]      t_lo,
  input  rbsi_pkg::slab_t [2:0]      t_hi,
  input  rbsi_pkg::side_t            side,
  output logic                       out_valid,
  output rbsi_pkg::result_t          out_res
);
  import rbsi_pkg::*;

  typedef struct packed {
    logic                   ok;
    slab_t                  tmin;
    slab_t                  tmax;
    logic [2:0][1:0]        n;
  } fold_t;

  logic                   vld  [0:2];
  fold_t                  fs   [0:2];
  slab_t [2:0]            ent  [0:2];
  slab_t [2:0]            ext  [0:2];
  logic [2:0][1:0]        ns   [0:2];
  logic [2:0]             par  [0:2];
  logic [2:0]             ins  [0:2];

  function automatic fold_t fold_axis(fold_t s, int a, slab_t e, slab_t x,
                                      logic [1:0] sg, logic p, logic in_slab);
    fold_t r;
    r = s;
    if (s.ok) begin
      if (p) begin
        r.ok = in_slab;
      end else begin
        if (e > s.tmin) begin
          r.tmin = e;
          r.n    = '0;
          r.n[a] = sg;
        end
        if (x < s.tmax) r.tmax = x;
        r.ok = (r.tmin <= r.tmax);
      end
    end
    return r;
  endfunction

  fold_t f0;
  fold_t f1;
  fold_t f2;

  always_comb begin
    f0.ok   = 1'b1;
    f0.tmin = '0;
    f0.tmax = $signed({2'b00, side.max_t});
    f0.n    = '0;
  end

  assign f1 = fold_axis(fs[0], 0, ent[0][0], ext[0][0], ns[0][0], par[0][0], ins[0][0]);
  assign f2 = fold_axis(fs[1], 1, ent[1][1], ext[1][1], ns[1][1], par[1][1], ins[1][1]);

  // stage 0: order entry and exit, entry face sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (t_lo[a] > t_hi[a]) begin
          ent[0][a] <= t_hi[a];
          ext[0][a] <= t_lo[a];
          ns[0][a]  <= 2'sd1;
        end else begin
          ent[0][a] <= t_lo[a];
          ext[0][a] <= t_hi[a];
          ns[0][a]  <= -2'sd1;
        end
      end
      fs[0]  <= f0;
      par[0] <= side.par;
      ins[0] <= side.in_slab;
      fs[1]  <= f1;
      fs[2]  <= f2;
      for (int k = 1; k < 3; k++) begin
        ent[k] <= ent[k-1];
        ext[k] <= ext[k-1];
        ns[k]  <= ns[k-1];
        par[k] <= par[k-1];
        ins[k] <= ins[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0]    <= 1'b0;
      vld[1]    <= 1'b0;
      vld[2]    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0]    <= side.valid;
      vld[1]    <= vld[0];
      vld[2]    <= vld[1];
      out_valid <= vld[2];
    end
  end

  fold_t f3;
  assign f3 = fold_axis(fs[2], 2, ent[2][2], ext[2][2], ns[2][2], par[2][2], ins[2][2]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.hit   <= f3.ok;
      out_res.hit_t <= f3.ok ? f3.tmin[30:0] : '0;
      out_res.nx    <= f3.ok ? f3.n[0] : '0;
      out_res.ny    <= f3.ok ? f3.n[1] : '0;
      out_res.nz    <= f3.ok ? f3.n[2] : '0;
    end
  end

endmodule

// ----- design/ray_box_slab_intersection_unit.sv -----
// Ray versus axis-aligned box slab test, fixed point, fully pipelined.
// Pipeline: 2 front stages, 33 divider stages and 4 fold stages; a box
//   transfer shows a result, load transfers give no result.
// Throughput: one item per cycle; the whole pipe advances together and
//   holds while the output register is full and not taken.
// Reset: rst is synchronous; clears valid bits, the stored ray and sets
//   parallel_threshold to 1.
module ray_box_slab_intersection_unit (
  input  logic         clk,
  input  logic         rst,
  // config: parallel_threshold
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  // slave side
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] vec_a_x, [63:32] vec_a_y, [95:64] vec_a_z, [127:96] vec_b_x,
  // [159:128] vec_b_y, [191:160] vec_b_z, [222:192] limit_t, [223] zero
  input  logic [223:0] s_tdata,
  // [0] operation
  input  logic         s_tuser,
  // master side
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] hit, [31:1] hit_t, [33:32] normal_x, [35:34] normal_y,
  // [37:36] normal_z, [39:38] zero
  output logic [39:0]  m_tdata
);
  import rbsi_pkg::*;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BOX  = 1'b1;

  logic        adv;
  logic        s_xfer;
  logic [15:0] parallel_threshold;

  logic [31:0] ray_origin    [0:2];
  logic [31:0] ray_direction [0:2];
  logic [30:0] ray_max_t;

  logic [31:0] in_a [0:2];
  logic [31:0] in_b [0:2];

  // whole pipe moves when the output register can take a new value
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign s_xfer   = s_tvalid && s_tready;

  for (genvar a = 0; a < 3; a++) begin : g_in
    assign in_a[a] = s_tdata[32*a +: 32];
    assign in_b[a] = s_tdata[96 + 32*a +: 32];
  end

  always_ff @(posedge clk) begin
    if (rst)
      parallel_threshold <= 16'd1;
    else if (cfg_wr_en)
      parallel_threshold <= cfg_wr_data;
  end

  // stored ray, replaced by each load transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        ray_origin[a]    <= '0;
        ray_direction[a] <= '0;
      end
      ray_max_t <= '0;
    end else if (s_xfer && s_tuser == OP_LOAD) begin
      for (int a = 0; a < 3; a++) begin
        ray_origin[a]    <= in_a[a];
        ray_direction[a] <= in_b[a];
      end
      ray_max_t <= s_tdata[222:192];
    end
  end

  // stage A: slab offsets, parallel and inside tests
  logic signed [32:0] a_num_lo [0:2];
  logic signed [32:0] a_num_hi [0:2];
  logic signed [31:0] a_dir    [0:2];
  side_t              a_side;

  logic [2:0] par_c;
  logic [2:0] ins_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [31:0] dmag;
      dmag     = ray_direction[a][31] ? 32'(-ray_direction[a]) : ray_direction[a];
      par_c[a] = (ray_direction[a] == '0) || (dmag < {16'd0, parallel_threshold});
      ins_c[a] = ($signed(ray_origin[a]) >= $signed(in_a[a])) &&
                 ($signed(ray_origin[a]) <= $signed(in_b[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        a_num_lo[a] <= $signed({in_a[a][31], in_a[a]}) -
                       $signed({ray_origin[a][31], ray_origin[a]});
        a_num_hi[a] <= $signed({in_b[a][31], in_b[a]}) -
                       $signed({ray_origin[a][31], ray_origin[a]});
        a_dir[a]    <= $signed(ray_direction[a]);
      end
      a_side.par     <= par_c;
      a_side.in_slab <= ins_c;
      a_side.max_t   <= ray_max_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      a_side.valid <= 1'b0;
    else if (adv)
      a_side.valid <= s_xfer && (s_tuser == OP_BOX);
  end

  // stage B: magnitudes and quotient signs for the dividers
  logic [31:0] b_nm_lo  [0:2];
  logic [31:0] b_nm_hi  [0:2];
  logic [31:0] b_dm     [0:2];
  logic        b_neg_lo [0:2];
  logic        b_neg_hi [0:2];
  side_t       b_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        b_nm_lo[a]  <= a_num_lo[a][32] ? 32'(-a_num_lo[a]) : a_num_lo[a][31:0];
        b_nm_hi[a]  <= a_num_hi[a][32] ? 32'(-a_num_hi[a]) : a_num_hi[a][31:0];
        b_dm[a]     <= a_dir[a][31] ? 32'(-a_dir[a]) : a_dir[a];
        b_neg_lo[a] <= a_num_lo[a][32] != a_dir[a][31];
        b_neg_hi[a] <= a_num_hi[a][32] != a_dir[a][31];
      end
      b_side.par     <= a_side.par;
      b_side.in_slab <= a_side.in_slab;
      b_side.max_t   <= a_side.max_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      b_side.valid <= 1'b0;
    else if (adv)
      b_side.valid <= a_side.valid;
  end

  // six dividers: low-plane and high-plane time on each axis
  slab_t [2:0] t_lo;
  slab_t [2:0] t_hi;

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbsi_div u_div_lo (
      .clk (clk),
      .en  (adv),
      .nm  (b_nm_lo[a]),
      .dm  (b_dm[a]),
      .neg (b_neg_lo[a]),
      .t   (t_lo[a])
    );
    rbsi_div u_div_hi (
      .clk (clk),
      .en  (adv),
      .nm  (b_nm_hi[a]),
      .dm  (b_dm[a]),
      .neg (b_neg_hi[a]),
      .t   (t_hi[a])
    );
  end

  // side info rides alongside the dividers; only the valid bits reset
  side_t sd [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) sd[k].valid <= 1'b0;
    end else if (adv) begin
      sd[0] <= b_side;
      for (int k = 1; k < DIV_LAT; k++) sd[k] <= sd[k-1];
    end
  end

  result_t res;

  rbsi_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .t_lo      (t_lo),
    .t_hi      (t_hi),
    .side      (sd[DIV_LAT-1]),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tdata = {2'b00, res.nz, res.ny, res.nx, res.hit_t, res.hit};

endmodule
